[sv/buffer_pool_frame_manager_assert.svh]
// assertion macros used by bpfm_ctrl
`ifndef BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH
`define BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH
`ifndef SYNTHESIS
`define BPFM_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define BPFM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define BPFM_ASSERT_NOW(lbl, pre, post)
`define BPFM_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

[sv/bpfm_pkg.sv]
`default_nettype none
package bpfm_pkg;
  localparam int NUM_FRAMES = 16;
  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  localparam logic [1:0] OP_PIN   = 2'd0;
  localparam logic [1:0] OP_UNPIN = 2'd1;
  localparam logic [1:0] OP_DIRTY = 2'd2;
  localparam logic [1:0] OP_FORCE = 2'd3;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_NOT_PINNED   = 2'd1;
  localparam logic [1:0] ST_NOT_IN_POOL  = 2'd2;
  localparam logic [1:0] ST_ALL_OCCUPIED = 2'd3;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_LRU  = 2'd1;
  localparam logic [1:0] POL_LFU  = 2'd2;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] page_number;
    logic        page_absent_on_disk;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame_index;
    logic        hit;
    logic        fetch_needed;
    logic        victim_writeback;
    logic [23:0] victim_page;
    logic        force_write;
  } out_res_t;

  typedef struct packed {
    logic [1:0]       policy;
    logic [CNT_W-1:0] nact;
  } cfg_t;

  // scan token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic [23:0]      page;
    logic             found;
    logic [IDX_W-1:0] fidx;
    logic             fpin_zero;
    logic             fpin_full;
    logic             empty_f;
    logic [IDX_W-1:0] eidx;
    logic             vic_f;
    logic [IDX_W-1:0] vidx;
    logic [31:0]      vload;
    logic [31:0]      vuse;
    logic [31:0]      vcnt;
    logic             vdirty;
    logic [23:0]      vpage;
  } carry_t;

  typedef enum logic [2:0] {
    U_HIT, U_LOAD, U_UNPIN, U_DIRTY, U_FORCE
  } upd_kind_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
    upd_kind_t        kind;
    logic [23:0]      page;
    logic             absent;
    logic [31:0]      stamp;
  } upd_t;
endpackage
`default_nettype wire

[sv/buffer_pool_frame_manager.sv]
// channel   | ports                           | handshake
// input     | start, busy, in_req             | taken when start and not busy
// result    | out_valid, out_res              | one-cycle strobe, no back pressure
// config    | psel penable pwrite paddr ...   | apb write, pready tied high
// a request passes a launch register, one register per frame cell as the scan token
// walks the cell chain, and a result register
// the update lands in the frame cell at the edge the scan ends
// busy is high from the accept edge until the result strobe cycle
// synchronous active-low reset empties every frame and clears the stamp clock
`default_nettype none
module buffer_pool_frame_manager (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bpfm_pkg::in_req_t  in_req,
  output logic                    out_valid,
  output bpfm_pkg::out_res_t      out_res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  bpfm_pkg::carry_t chain [bpfm_pkg::NUM_FRAMES+1];
  bpfm_pkg::cfg_t   cfg;
  bpfm_pkg::upd_t   upd;

  // sequencer and registers
  bpfm_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_res,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg, .launch(chain[0]), .tail(chain[bpfm_pkg::NUM_FRAMES]), .upd
  );

  // frame cells in a chain
  for (genvar i = 0; i < bpfm_pkg::NUM_FRAMES; i++) begin : g_cell
    bpfm_cell u_cell (
      .clk, .rst_n,
      .cell_idx(bpfm_pkg::IDX_W'(i)),
      .cfg, .upd,
      .carry_in(chain[i]),
      .carry_out(chain[i+1])
    );
  end
endmodule
`default_nettype wire

[sv/bpfm_cell.sv]
`default_nettype none
module bpfm_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [bpfm_pkg::IDX_W-1:0]  cell_idx,
  input  wire bpfm_pkg::cfg_t              cfg,
  input  wire bpfm_pkg::upd_t              upd,
  input  wire bpfm_pkg::carry_t            carry_in,
  output bpfm_pkg::carry_t                 carry_out
);
  logic        mapped_r, dirty_r;
  logic [23:0] page_r;
  logic [7:0]  pin_r;
  logic [31:0] load_r, use_r, cnt_r;
  bpfm_pkg::carry_t carry_r, carry_nxt;
  logic active, better, mine;

  assign active = {1'b0, cell_idx} < cfg.nact;

  // victim ranking against the best so far
  always_comb begin
    case (cfg.policy)
      bpfm_pkg::POL_FIFO: better = load_r < carry_in.vload;
      bpfm_pkg::POL_LRU:  better = use_r < carry_in.vuse;
      default: begin
        better = (cnt_r != carry_in.vcnt) ? (cnt_r < carry_in.vcnt)
                                          : (load_r < carry_in.vload);
      end
    endcase
  end

  // fold this frame into the token
  always_comb begin
    carry_nxt = carry_in;
    if (active && mapped_r && !carry_in.found && page_r == carry_in.page) begin
      carry_nxt.found     = 1'b1;
      carry_nxt.fidx      = cell_idx;
      carry_nxt.fpin_zero = pin_r == 8'd0;
      carry_nxt.fpin_full = pin_r == 8'd255;
    end
    if (active && !mapped_r && !carry_in.empty_f) begin
      carry_nxt.empty_f = 1'b1;
      carry_nxt.eidx    = cell_idx;
    end
    if (active && pin_r == 8'd0 && (!carry_in.vic_f || better)) begin
      carry_nxt.vic_f  = 1'b1;
      carry_nxt.vidx   = cell_idx;
      carry_nxt.vload  = load_r;
      carry_nxt.vuse   = use_r;
      carry_nxt.vcnt   = cnt_r;
      carry_nxt.vdirty = dirty_r;
      carry_nxt.vpage  = page_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) carry_r.valid <= 1'b0;
    else carry_r.valid <= carry_nxt.valid;
    carry_r[$bits(bpfm_pkg::carry_t)-2:0] <= carry_nxt[$bits(bpfm_pkg::carry_t)-2:0];
  end
  assign carry_out = carry_r;

  assign mine = upd.valid && upd.idx == cell_idx;

  // apply the broadcast update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= 1'b0;
      dirty_r  <= 1'b0;
      page_r   <= '0;
      pin_r    <= '0;
      load_r   <= '0;
      use_r    <= '0;
      cnt_r    <= '0;
    end else if (mine) begin
      case (upd.kind)
        bpfm_pkg::U_HIT: begin
          use_r <= upd.stamp;
          if (cnt_r != 32'hFFFF_FFFF) cnt_r <= cnt_r + 32'd1;
          if (pin_r != 8'd255) pin_r <= pin_r + 8'd1;
        end
        bpfm_pkg::U_LOAD: begin
          mapped_r <= 1'b1;
          page_r   <= upd.page;
          dirty_r  <= upd.absent;
          load_r   <= upd.stamp;
          use_r    <= upd.stamp;
          cnt_r    <= 32'd1;
          pin_r    <= 8'd1;
        end
        bpfm_pkg::U_UNPIN: pin_r <= pin_r - 8'd1;
        bpfm_pkg::U_DIRTY: dirty_r <= 1'b1;
        bpfm_pkg::U_FORCE: dirty_r <= 1'b0;
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[sv/bpfm_ctrl.sv]
`default_nettype none
module bpfm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bpfm_pkg::in_req_t  in_req,
  output logic                    out_valid,
  output bpfm_pkg::out_res_t      out_res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output bpfm_pkg::cfg_t          cfg,
  output bpfm_pkg::carry_t        launch,
  input  wire bpfm_pkg::carry_t   tail,
  output bpfm_pkg::upd_t          upd
);
  typedef enum logic [1:0] {S_IDLE = 2'b01, S_SCAN = 2'b10} state_t;
  state_t state_r, state_nxt;
  logic [1:0]  policy_r;
  logic [4:0]  frames_r;
  logic [31:0] stamp_r, stamp_nxt;
  logic [11:0] pinned_r, pinned_nxt;
  bpfm_pkg::in_req_t  req_r;
  bpfm_pkg::carry_t   launch_r;
  bpfm_pkg::out_res_t res_nxt, res_r;
  logic out_valid_r, accept, done;

  assign pready = 1'b1;
  assign busy   = state_r != S_IDLE;
  assign accept = start && !busy;
  assign done   = state_r == S_SCAN && tail.valid;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= bpfm_pkg::POL_FIFO;
      frames_r <= 5'd16;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == bpfm_pkg::REG_POLICY) policy_r <= pwdata[1:0];
      else frames_r <= pwdata[4:0];
    end
  end
  assign prdata = (paddr[2] == bpfm_pkg::REG_FRAMES) ? {27'd0, frames_r} : {30'd0, policy_r};

  assign cfg.policy = policy_r;
  assign cfg.nact = (frames_r > 5'(bpfm_pkg::NUM_FRAMES)) ?
                    bpfm_pkg::CNT_W'(bpfm_pkg::NUM_FRAMES) : bpfm_pkg::CNT_W'(frames_r);

  // launch token for the chain
  always_ff @(posedge clk) begin
    if (!rst_n) launch_r.valid <= 1'b0;
    else launch_r.valid <= accept;
    if (accept) begin
      launch_r.page    <= in_req.page_number;
      launch_r.found   <= 1'b0;
      launch_r.empty_f <= 1'b0;
      launch_r.vic_f   <= 1'b0;
      req_r            <= in_req;
    end
    launch_r.fidx <= '0; launch_r.fpin_zero <= 1'b0; launch_r.fpin_full <= 1'b0;
    launch_r.eidx <= '0; launch_r.vidx <= '0; launch_r.vload <= '0;
    launch_r.vuse <= '0; launch_r.vcnt <= '0; launch_r.vdirty <= 1'b0;
    launch_r.vpage <= '0;
  end
  assign launch = launch_r;

  // decision on the finished scan
  always_comb begin
    res_nxt    = '0;
    upd        = '0;
    upd.kind   = bpfm_pkg::U_HIT;
    upd.page   = req_r.page_number;
    upd.absent = req_r.page_absent_on_disk;
    upd.stamp  = stamp_r;
    stamp_nxt  = stamp_r;
    pinned_nxt = pinned_r;
    case (req_r.op)
      bpfm_pkg::OP_PIN: begin
        if (tail.found) begin
          res_nxt.hit = 1'b1;
          upd.idx     = tail.fidx;
          if (!tail.fpin_full && pinned_r != 12'd4095) pinned_nxt = pinned_r + 12'd1;
        end else if (tail.empty_f || (tail.vic_f && policy_r <= bpfm_pkg::POL_LFU)) begin
          upd.kind = bpfm_pkg::U_LOAD;
          upd.idx  = tail.empty_f ? tail.eidx : tail.vidx;
          res_nxt.fetch_needed = !req_r.page_absent_on_disk;
          if (!tail.empty_f && tail.vdirty) begin
            res_nxt.victim_writeback = 1'b1;
            res_nxt.victim_page      = tail.vpage;
          end
          if (pinned_r != 12'd4095) pinned_nxt = pinned_r + 12'd1;
        end else begin
          res_nxt.status = bpfm_pkg::ST_ALL_OCCUPIED;
        end
        if (res_nxt.status == bpfm_pkg::ST_OK) stamp_nxt = stamp_r + 32'd1;
      end
      bpfm_pkg::OP_UNPIN: begin
        upd.kind = bpfm_pkg::U_UNPIN;
        upd.idx  = tail.fidx;
        if (!tail.found) res_nxt.status = bpfm_pkg::ST_NOT_IN_POOL;
        else if (tail.fpin_zero) res_nxt.status = bpfm_pkg::ST_NOT_PINNED;
        else if (pinned_r != 12'd0) pinned_nxt = pinned_r - 12'd1;
      end
      bpfm_pkg::OP_DIRTY: begin
        upd.kind = bpfm_pkg::U_DIRTY;
        upd.idx  = tail.fidx;
        if (!tail.found) res_nxt.status = bpfm_pkg::ST_NOT_PINNED;
      end
      default: begin
        upd.kind = bpfm_pkg::U_FORCE;
        upd.idx  = tail.fidx;
        if (!tail.found) res_nxt.status = bpfm_pkg::ST_NOT_IN_POOL;
        else res_nxt.force_write = 1'b1;
      end
    endcase
    upd.valid = done && res_nxt.status == bpfm_pkg::ST_OK;
    if (res_nxt.status == bpfm_pkg::ST_OK) res_nxt.frame_index = 4'(upd.idx);
    if (!done) begin
      stamp_nxt  = stamp_r;
      pinned_nxt = pinned_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_SCAN;
      S_SCAN:  if (done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      stamp_r     <= '0;
      pinned_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      stamp_r     <= stamp_nxt;
      pinned_r    <= pinned_nxt;
    end
    if (done) res_r <= res_nxt;
  end
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

`include "buffer_pool_frame_manager_assert.svh"
  `BPFM_ASSERT_NEXT(a_accept_busy, accept, busy)
  `BPFM_ASSERT_NEXT(a_done_strobe, done, out_valid && !busy)
  `BPFM_ASSERT_NOW(a_tail_only_scan, tail.valid, state_r == S_SCAN)
  `BPFM_ASSERT_NOW(a_fail_index, out_valid && out_res.status != bpfm_pkg::ST_OK,
                   out_res.frame_index == 4'd0 && !out_res.hit && !out_res.force_write)
endmodule
`default_nettype wire
